// ===== src/lmbs_pkg.sv =====
package lmbs_pkg;

	// Frame geometry. The frame is always sixteen rows of two bytes.
	localparam int FRAME_ROWS   = 16;
	localparam int ROW_W        = $clog2(FRAME_ROWS);
	localparam int GLYPH_BYTE_W = 5;

	// Default glyph table depth per direction.
	localparam int MAX_GLYPHS_DEFAULT = 16;

	// Reset values of the registers.
	localparam logic [4:0] GLYPH_COUNT_RESET  = 5'd1;
	localparam logic [7:0] TICK_DIVIDER_RESET = 8'd5;
	localparam logic [7:0] LEFT_MASK_RESET    = 8'h80;
	localparam logic [7:0] RIGHT_MASK_RESET   = 8'h01;

	// Register indexes on the configuration port.
	localparam logic [0:0] REG_GLYPH_COUNT  = 1'b0;
	localparam logic [0:0] REG_TICK_DIVIDER = 1'b1;

	// Input opcodes.
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	// Scroll directions.
	localparam logic DIR_LEFT  = 1'b0;
	localparam logic DIR_RIGHT = 1'b1;

	// One frame row: left byte in the upper half, right byte in the lower half.
	typedef logic [15:0] frame_row_t;

	localparam frame_row_t BLANK_ROW = 16'hFFFF;

	typedef enum logic {
		ST_IDLE,
		ST_SHIFT
	} state_t;

	typedef struct packed {
		logic       opcode;
		logic       table_select;
		logic [3:0] glyph_index;
		logic [4:0] byte_index;
		logic [7:0] byte_data;
	} in_item_t;

	typedef struct packed {
		logic [3:0] row_index;
		logic [7:0] left_byte;
		logic [7:0] right_byte;
		logic       scroll_right;
		logic       last_row;
	} out_item_t;

	// Moves a row by one column and inserts the new dot at the incoming edge, or blanks it.
	// A leftward move enters at the right edge, a rightward move at the left.
	function automatic frame_row_t shift_row(frame_row_t row, logic dir, logic fill,
			logic blank);
		frame_row_t res;
		if (dir == DIR_LEFT) begin
			res = {row[14:0], fill};
		end else begin
			res = {fill, row[15:1]};
		end
		if (blank) begin
			res = BLANK_ROW;
		end
		return res;
	endfunction

endpackage

// ===== src/led_matrix_bounce_scroller.sv =====
// Channel  | Handshake          | Payload
// ---------+--------------------+--------------------------------------------
// in       | in_valid/in_stall  | in_data  (opcode, table, glyph, byte, data)
// out      | out_valid/out_stall| out_data (row, left, right, direction, last)
// cfg      | cfg_we             | cfg_index, cfg_data
//
// A load, or a tick that does not reach the divider, leaves the scroller idle.
// A tick that shifts starts a rotation: the sixteen frame rows rotate once
// through the cell chain, one row per cycle, each reading one glyph byte
// from the single read port of the glyph memory.
// A stall on the output freezes the rotation; in_stall stays high until the
// last row has entered the output register.
// Reset clears the frame to blank; the glyph memory holds nothing until loaded.
module led_matrix_bounce_scroller
	import lmbs_pkg::*;
#(
	parameter int MAX_GLYPHS = MAX_GLYPHS_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_data,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_data
);

	// Widths that follow from the glyph table depth.
	localparam int GW        = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
	localparam int GIW       = ($clog2(MAX_GLYPHS + 1) > 4) ? $clog2(MAX_GLYPHS + 1) : 4;
	localparam int SCW       = $clog2((MAX_GLYPHS + 1) * 16 + 1);
	localparam int WW        = SCW - 4;
	localparam int CW        = (WW > 5) ? WW : 5;
	localparam int AW        = 1 + GW + GLYPH_BYTE_W;
	localparam int MEM_DEPTH = 1 << AW;

	// Configuration registers.
	logic [4:0] glyph_count_q;
	logic [7:0] tick_divider_q;

	// Scroll state.
	state_t          state_q, state_d;
	logic [ROW_W-1:0] cnt_q;
	logic [7:0]      tick_count_q;
	logic [SCW-1:0]  shift_count_q;
	logic            dir_q;
	logic [7:0]      left_mask_q;
	logic [7:0]      right_mask_q;

	// Output register.
	logic      out_valid_q;
	out_item_t out_data_q;

	// Glyph memory.
	logic [7:0] glyph_mem [MEM_DEPTH];
	logic [7:0] rd_data_q;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic          mem_we;

	logic             in_accept;
	logic             out_free;
	logic             step;
	logic             last_step;
	logic [7:0]       tick_next;
	logic             tick_hit;
	logic             shift_start;
	logic [ROW_W-1:0] rd_row;
	logic [GIW-1:0]   glyph_ext;
	logic [WW-1:0]    word;
	logic             half;
	logic [CW-1:0]    eff;
	logic [CW-1:0]    word_c;
	logic [SCW-1:0]   shift_next;
	logic [CW:0]      pass_words;
	logic             end_pass;
	logic             dir_after;
	logic [7:0]       mask;
	logic             fill;
	frame_row_t       head_row;
	frame_row_t       new_row;
	frame_row_t       cell_row [FRAME_ROWS];

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_count_q  <= GLYPH_COUNT_RESET;
			tick_divider_q <= TICK_DIVIDER_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GLYPH_COUNT:  glyph_count_q  <= cfg_data[4:0];
				REG_TICK_DIVIDER: tick_divider_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input transfer decode.
	assign in_accept   = in_valid && !in_stall;
	assign tick_next   = tick_count_q + 8'd1;
	assign tick_hit    = (tick_next >= tick_divider_q);
	assign shift_start = in_accept && (in_data.opcode == OP_TICK) && tick_hit;
	assign out_free    = !out_valid_q || !out_stall;
	assign last_step   = step && (cnt_q == ROW_W'(FRAME_ROWS - 1));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (shift_start) state_d = ST_SHIFT;
			ST_SHIFT: if (last_step) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		in_stall = 1'b1;
		step     = 1'b0;
		rd_row   = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_SHIFT: begin
				step   = out_free;
				rd_row = out_free ? ROW_W'(cnt_q + 1'b1) : cnt_q;
			end
			default: ;
		endcase
	end

	// Position of the incoming column within the glyph sequence.
	assign word       = shift_count_q[SCW-1:4];
	assign half       = dir_q ? ~shift_count_q[3] : shift_count_q[3];
	assign eff        = (CW'(glyph_count_q) > CW'(MAX_GLYPHS)) ? CW'(MAX_GLYPHS)
	                                                            : CW'(glyph_count_q);
	assign word_c     = CW'(word);
	assign shift_next = shift_count_q + 1'b1;
	assign pass_words = (CW + 1)'(eff) + 1'b1;
	assign end_pass   = ((CW + 1)'(shift_next[SCW-1:4]) >= pass_words);
	assign dir_after  = end_pass ? ~dir_q : dir_q;

	// Glyph memory: one write port for loads, one registered read port.
	assign glyph_ext = GIW'(in_data.glyph_index);
	assign mem_we    = in_accept && (in_data.opcode == OP_LOAD)
	                   && (glyph_ext < GIW'(MAX_GLYPHS));
	assign wr_addr   = {in_data.table_select, glyph_ext[GW-1:0], in_data.byte_index};
	assign rd_addr   = {dir_q, word[GW-1:0], half, rd_row};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			glyph_mem[wr_addr] <= in_data.byte_data;
		end
		rd_data_q <= glyph_mem[rd_addr];
	end

	// New dot for the head row; past the last glyph the column stays blank.
	assign mask     = dir_q ? right_mask_q : left_mask_q;
	assign fill     = (word_c < eff) ? |(rd_data_q & mask) : 1'b1;
	assign head_row = cell_row[0];
	assign new_row  = shift_row(head_row, dir_q, fill, (dir_q == DIR_LEFT) && end_pass);

	// Cell chain: rows rotate toward cell 0, the shifted head row enters at the tail.
	for (genvar i = 0; i < FRAME_ROWS; i++) begin : g_cell
		frame_row_t cell_in;
		if (i == FRAME_ROWS - 1) begin : g_tail
			assign cell_in = new_row;
		end else begin : g_mid
			assign cell_in = cell_row[i+1];
		end
		lmbs_row_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (step),
			.row_in  (cell_in),
			.row     (cell_row[i])
		);
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			tick_count_q  <= '0;
			shift_count_q <= '0;
			dir_q         <= DIR_LEFT;
			left_mask_q   <= LEFT_MASK_RESET;
			right_mask_q  <= RIGHT_MASK_RESET;
		end else begin
			state_q <= state_d;
			if (in_accept && (in_data.opcode == OP_TICK)) begin
				tick_count_q <= tick_hit ? 8'd0 : tick_next;
			end
			if (step) begin
				cnt_q <= ROW_W'(cnt_q + 1'b1);
			end
			// Pass bookkeeping once the whole frame has moved.
			if (last_step) begin
				shift_count_q <= end_pass ? '0 : shift_next;
				dir_q         <= dir_after;
				if (dir_q == DIR_LEFT) begin
					left_mask_q <= {left_mask_q[0], left_mask_q[7:1]};
				end else begin
					right_mask_q <= {right_mask_q[6:0], right_mask_q[7]};
				end
			end
		end
	end

	// Output register: loaded with each finished row, cleared by a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q.row_index    <= cnt_q;
			out_data_q.left_byte    <= new_row[15:8];
			out_data_q.right_byte   <= new_row[7:0];
			out_data_q.scroll_right <= dir_after;
			out_data_q.last_row     <= (cnt_q == ROW_W'(FRAME_ROWS - 1));
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== src/lmbs_row_cell.sv =====
module lmbs_row_cell
	import lmbs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  frame_row_t row_in,
	output frame_row_t row
);

	frame_row_t row_q;

	// Each cell holds one frame row and takes its row_in on every advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= BLANK_ROW;
		end else if (advance) begin
			row_q <= row_in;
		end
	end

	assign row = row_q;

endmodule

// ===== src/lmbs_checker.sv =====
module lmbs_checker
	import lmbs_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	// The last row of a frame is always row fifteen.
	a_last_row_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last_row |-> out_data.row_index == 4'(FRAME_ROWS - 1))
		else $error("last_row flagged on a row other than the final one");

	// Within a frame, the next row follows right after a transfer, in order and
	// with the same direction.
	a_row_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.last_row |=>
			out_valid && (out_data.row_index == $past(out_data.row_index) + 1'b1)
			&& (out_data.scroll_right == $past(out_data.scroll_right)))
		else $error("frame rows not delivered back to back in order");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output changed");

	// The input side opens again only once the last row of a frame is out.
	a_input_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_stall) |-> out_valid && out_data.last_row)
		else $error("input reopened before the frame was complete");

endmodule

bind led_matrix_bounce_scroller lmbs_checker u_lmbs_checker (.*);
